@@ rtl/eaj_pkg.sv @@
`default_nettype none
package eaj_pkg;

    localparam logic [1:0] CFG_FOCAL_X  = 2'd0;
    localparam logic [1:0] CFG_FOCAL_Y  = 2'd1;
    localparam logic [1:0] CFG_CENTER_X = 2'd2;
    localparam logic [1:0] CFG_CENTER_Y = 2'd3;

    localparam int QBITS = 32;

    typedef struct packed {
        logic [15:0]      rem;
        logic [QBITS-1:0] num;
        logic [QBITS-1:0] q;
        logic [15:0]      den;
    } t_div;

    typedef struct packed {
        logic               neg_a;
        logic               neg_b;
        logic               zero;
        logic signed [31:0] gx;
        logic signed [31:0] gy;
    } t_side;

    function automatic t_div div_step(input t_div x);
        logic [16:0] trial;
        logic [16:0] diff;
        logic        ge;
        t_div        y;
        trial = {x.rem, x.num[QBITS-1]};
        diff  = trial - {1'b0, x.den};
        ge    = (trial >= {1'b0, x.den});
        y.rem = ge ? diff[15:0] : trial[15:0];
        y.num = {x.num[QBITS-2:0], 1'b0};
        y.q   = {x.q[QBITS-2:0], ge};
        y.den = x.den;
        return y;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
        logic signed [31:0] y;
        if (x > 68'sd2147483647) begin
            y = 32'sh7FFFFFFF;
        end else if (x < -68'sd2147483648) begin
            y = 32'sh80000000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    function automatic logic signed [31:0] clamp31(input logic signed [67:0] x);
        logic signed [31:0] y;
        if (x > 68'sd2147483647) begin
            y = 32'sh7FFFFFFF;
        end else if (x < -68'sd2147483647) begin
            y = -32'sh7FFFFFFF;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

    function automatic logic signed [35:0] clamp35(input logic signed [67:0] x);
        logic signed [35:0] y;
        if (x > 68'sd34359738367) begin
            y = 36'sh7FFFFFFFF;
        end else if (x < -68'sd34359738367) begin
            y = -36'sh7FFFFFFFF;
        end else begin
            y = x[35:0];
        end
        return y;
    endfunction

endpackage
`default_nettype wire

@@ rtl/edge_alignment_jacobian.sv @@
// Computes the six SE(3) Jacobian terms of one edge point per beat. A beat is accepted in
// every cycle while the output skid slot is empty, and its result reaches the master side
// through an input register, the three 32-stage restoring quotient pipelines (normalized
// ray a and b, and inverse depth) that run side by side, a quotient fix-up stage, four
// stages of multiplies, clamps and sums, and the output register. Intrinsics must only be
// written while the block is idle.
`default_nettype none
module edge_alignment_jacobian
    import eaj_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_addr,
    input  wire logic [15:0]  i_cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // pixel_u, pixel_v, point_depth, grad_u, grad_v
    input  wire logic [79:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // jac_tx, jac_ty, jac_tz, jac_rx, jac_ry, jac_rz
    output logic [191:0]      m_axis_tdata,
    // depth_invalid
    output logic              m_axis_tuser
);

    localparam int NST = QBITS;

    logic [15:0] r_focal_x, r_focal_y, r_center_x, r_center_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= 16'd8400;
            r_focal_y  <= 16'd8400;
            r_center_x <= 16'd5112;
            r_center_y <= 16'd3832;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_FOCAL_X:  r_focal_x  <= i_cfg_data;
                CFG_FOCAL_Y:  r_focal_y  <= i_cfg_data;
                CFG_CENTER_X: r_center_x <= i_cfg_data;
                CFG_CENTER_Y: r_center_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic ce;
    logic r_skid_v;
    assign ce = !r_skid_v;
    assign s_axis_tready = ce;

    logic [15:0]  in_u, in_v, in_depth;
    logic [16:0]  du, dv;
    logic [15:0]  mag_u, mag_v;
    logic         acc;
    t_div         n_da0, n_db0, n_dw0;
    t_side        n_sd0, n_sd1;

    t_div  r_da [0:NST];
    t_div  r_db [0:NST];
    t_div  r_dw [0:NST];
    t_side r_sd [0:NST];
    logic  r_v  [0:NST];

    assign acc      = s_axis_tvalid && ce;
    assign in_u     = s_axis_tdata[15:0];
    assign in_v     = s_axis_tdata[31:16];
    assign in_depth = s_axis_tdata[47:32];
    assign du       = {1'b0, in_u} - {1'b0, r_center_x};
    assign dv       = {1'b0, in_v} - {1'b0, r_center_y};

    always_comb begin
        mag_u      = du[16] ? 16'(-du) : du[15:0];
        mag_v      = dv[16] ? 16'(-dv) : dv[15:0];
        n_da0.rem  = '0;
        n_da0.num  = {mag_u, 16'd0};
        n_da0.q    = '0;
        n_da0.den  = (r_focal_x == 16'd0) ? 16'd1 : r_focal_x;
        n_db0.rem  = '0;
        n_db0.num  = {mag_v, 16'd0};
        n_db0.q    = '0;
        n_db0.den  = (r_focal_y == 16'd0) ? 16'd1 : r_focal_y;
        n_dw0.rem  = '0;
        n_dw0.num  = 32'h1000_0000;
        n_dw0.q    = '0;
        n_dw0.den  = in_depth;
        n_sd0.neg_a = du[16];
        n_sd0.neg_b = dv[16];
        n_sd0.zero  = (in_depth == 16'd0);
        n_sd0.gx    = 32'(signed'(s_axis_tdata[63:48]));
        n_sd0.gy    = 32'(signed'(s_axis_tdata[79:64]));
        n_sd1       = r_sd[0];
        n_sd1.gx    = $signed({1'b0, r_focal_x}) * r_sd[0].gx;
        n_sd1.gy    = $signed({1'b0, r_focal_y}) * r_sd[0].gy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NST; k++) begin
                r_v[k] <= 1'b0;
            end
        end else if (ce) begin
            r_v[0] <= acc;
            for (int k = 0; k < NST; k++) begin
                r_v[k+1] <= r_v[k];
            end
        end
        if (ce) begin
            r_da[0] <= n_da0;
            r_db[0] <= n_db0;
            r_dw[0] <= n_dw0;
            r_sd[0] <= n_sd0;
            r_sd[1] <= n_sd1;
            for (int k = 0; k < NST; k++) begin
                r_da[k+1] <= div_step(r_da[k]);
                r_db[k+1] <= div_step(r_db[k]);
                r_dw[k+1] <= div_step(r_dw[k]);
            end
            for (int k = 1; k < NST; k++) begin
                r_sd[k+1] <= r_sd[k];
            end
        end
    end

    // Quotient fix-up stage.
    logic               r_qv, r_qzero;
    logic signed [31:0] r_a, r_b, r_qgx, r_qgy;
    logic        [28:0] r_w;
    logic        [30:0] mag_a, mag_b;

    always_comb begin
        mag_a = (r_da[NST].q > 32'h7FFF_FFFF) ? 31'h7FFF_FFFF : r_da[NST].q[30:0];
        mag_b = (r_db[NST].q > 32'h7FFF_FFFF) ? 31'h7FFF_FFFF : r_db[NST].q[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qv <= 1'b0;
        end else if (ce) begin
            r_qv <= r_v[NST];
        end
        if (ce) begin
            r_a     <= r_sd[NST].neg_a ? -$signed({1'b0, mag_a}) : $signed({1'b0, mag_a});
            r_b     <= r_sd[NST].neg_b ? -$signed({1'b0, mag_b}) : $signed({1'b0, mag_b});
            r_w     <= r_dw[NST].q[28:0];
            r_qgx   <= r_sd[NST].gx;
            r_qgy   <= r_sd[NST].gy;
            r_qzero <= r_sd[NST].zero;
        end
    end

    // First product stage.
    logic               r_p1v, r_p1zero;
    logic signed [63:0] r_aa, r_bb, r_ab, r_agx, r_bgy, r_bgx, r_agy, r_gxw, r_gyw;
    logic signed [31:0] r_p1gx, r_p1gy;
    logic        [28:0] r_p1w;
    logic signed [29:0] w_s;

    assign w_s = $signed({1'b0, r_w});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1v <= 1'b0;
        end else if (ce) begin
            r_p1v <= r_qv;
        end
        if (ce) begin
            r_aa     <= r_a * r_a;
            r_bb     <= r_b * r_b;
            r_ab     <= r_a * r_b;
            r_agx    <= r_a * r_qgx;
            r_bgy    <= r_b * r_qgy;
            r_bgx    <= r_b * r_qgx;
            r_agy    <= r_a * r_qgy;
            r_gxw    <= r_qgx * w_s;
            r_gyw    <= r_qgy * w_s;
            r_p1gx   <= r_qgx;
            r_p1gy   <= r_qgy;
            r_p1w    <= r_w;
            r_p1zero <= r_qzero;
        end
    end

    // Clamp and sum stage.
    logic               r_p2v, r_p2zero;
    logic signed [31:0] r_pa, r_pb, r_ab2, r_tx2, r_ty2, r_rz2, r_p2gx, r_p2gy;
    logic signed [35:0] r_s;
    logic        [28:0] r_p2w;
    logic signed [31:0] aa_c, bb_c;

    always_comb begin
        aa_c = clamp31(68'(r_aa >>> 16));
        bb_c = clamp31(68'(r_bb >>> 16));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2v <= 1'b0;
        end else if (ce) begin
            r_p2v <= r_p1v;
        end
        if (ce) begin
            r_pa     <= clamp31(68'(aa_c) + 68'sd65536);
            r_pb     <= clamp31(68'(bb_c) + 68'sd65536);
            r_ab2    <= clamp31(68'(r_ab >>> 16));
            r_s      <= clamp35(68'(r_agx >>> 18) + 68'(r_bgy >>> 18));
            r_tx2    <= sat32(68'(r_gxw >>> 18));
            r_ty2    <= sat32(68'(r_gyw >>> 18));
            r_rz2    <= sat32((68'(r_agy) - 68'(r_bgx)) >>> 18);
            r_p2gx   <= r_p1gx;
            r_p2gy   <= r_p1gy;
            r_p2w    <= r_p1w;
            r_p2zero <= r_p1zero;
        end
    end

    // Second product stage.
    logic               r_p3v, r_p3zero;
    logic signed [63:0] r_abgx, r_pbgy, r_pagx, r_abgy;
    logic signed [65:0] r_sw;
    logic signed [31:0] r_tx3, r_ty3, r_rz3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3v <= 1'b0;
        end else if (ce) begin
            r_p3v <= r_p2v;
        end
        if (ce) begin
            r_abgx   <= r_ab2 * r_p2gx;
            r_pbgy   <= r_pb * r_p2gy;
            r_pagx   <= r_pa * r_p2gx;
            r_abgy   <= r_ab2 * r_p2gy;
            r_sw     <= r_s * $signed({1'b0, r_p2w});
            r_tx3    <= r_tx2;
            r_ty3    <= r_ty2;
            r_rz3    <= r_rz2;
            r_p3zero <= r_p2zero;
        end
    end

    // Final sums, saturation and the zero-depth override.
    logic         r_p4v;
    logic [192:0] r_p4;
    logic signed [31:0] rx4, ry4, tz4;

    always_comb begin
        rx4 = sat32((-68'(r_abgx) - 68'(r_pbgy)) >>> 18);
        ry4 = sat32((68'(r_pagx) + 68'(r_abgy)) >>> 18);
        tz4 = sat32((-68'(r_sw)) >>> 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4v <= 1'b0;
        end else if (ce) begin
            r_p4v <= r_p3v;
        end
        if (ce) begin
            if (r_p3zero) begin
                r_p4 <= {1'b1, 192'd0};
            end else begin
                r_p4 <= {1'b0, r_rz3, ry4, rx4, tz4, r_ty3, r_tx3};
            end
        end
    end

    // Output register with one skid slot.
    logic         r_out_v;
    logic [192:0] r_out, r_skid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (m_axis_tready) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || m_axis_tready) begin
            r_out_v <= r_p4v;
        end else if (r_p4v) begin
            r_skid_v <= 1'b1;
        end
        if (r_skid_v) begin
            if (m_axis_tready) begin
                r_out <= r_skid;
            end
        end else if (!r_out_v || m_axis_tready) begin
            r_out <= r_p4;
        end else begin
            r_skid <= r_p4;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out[191:0];
    assign m_axis_tuser  = r_out[192];

endmodule
`default_nettype wire

@@ sim/tb_edge_alignment_jacobian.sv @@
`default_nettype none
module tb_edge_alignment_jacobian;
    import eaj_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 38;
    localparam int STALL_LIMIT = 20000;
    localparam longint LIM31 = 64'sd2147483647;
    localparam longint LIM35 = 64'sd34359738367;

    typedef struct packed {
        logic [15:0] grad_v;
        logic [15:0] grad_u;
        logic [15:0] depth;
        logic [15:0] pix_v;
        logic [15:0] pix_u;
    } t_point;

    typedef struct {
        logic [31:0] jac [6];
        logic        invalid;
    } t_jac;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_addr;
    logic [15:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [79:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [191:0] m_axis_tdata;
    logic         m_axis_tuser;

    logic [15:0] fx_reg, fy_reg, cx_reg, cy_reg;
    t_jac        jac_expected [$];
    int          fail_count;
    int          idle_cycles;
    bit          sink_stall_long;

    edge_alignment_jacobian dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic longint floor_sh(longint x, int s);
        return x >>> s;
    endfunction

    function automatic longint clip(longint x, longint lo, longint hi);
        return x < lo ? lo : (x > hi ? hi : x);
    endfunction

    function automatic logic [31:0] sat_q16(longint x);
        longint y;
        y = clip(x, -LIM31 - 1, LIM31);
        return y[31:0];
    endfunction

    function automatic longint norm_ray(logic [15:0] pix, logic [15:0] ctr, logic [15:0] f);
        longint d, q, fd;
        d  = longint'(pix) - longint'(ctr);
        fd = (f == 0) ? 1 : longint'(f);
        q  = (d * 65536) / fd;
        return clip(q, -LIM31, LIM31);
    endfunction

    // Products of a full-range ray and a scaled gradient can exceed 64 bits only
    // beyond what the clamps allow, so 64-bit arithmetic matches the block.
    function automatic t_jac predict_jacobian(t_point p);
        t_jac   r;
        longint a, b, w, gx, gy, aa, bb, ab, pa, pb, s;
        if (p.depth == 0) begin
            for (int k = 0; k < 6; k++) r.jac[k] = '0;
            r.invalid = 1'b1;
            return r;
        end
        a  = norm_ray(p.pix_u, cx_reg, fx_reg);
        b  = norm_ray(p.pix_v, cy_reg, fy_reg);
        w  = (64'sd1 << 28) / longint'(p.depth);
        gx = longint'(fx_reg) * longint'($signed(p.grad_u));
        gy = longint'(fy_reg) * longint'($signed(p.grad_v));
        aa = clip(floor_sh(a * a, 16), -LIM31, LIM31);
        bb = clip(floor_sh(b * b, 16), -LIM31, LIM31);
        ab = clip(floor_sh(a * b, 16), -LIM31, LIM31);
        pa = clip(aa + 65536, -LIM31, LIM31);
        pb = clip(bb + 65536, -LIM31, LIM31);
        s  = clip(floor_sh(a * gx, 18) + floor_sh(b * gy, 18), -LIM35, LIM35);
        r.jac[0] = sat_q16(floor_sh(gx * w, 18));
        r.jac[1] = sat_q16(floor_sh(gy * w, 18));
        r.jac[2] = sat_q16(floor_sh(-s * w, 16));
        r.jac[3] = sat_q16(floor_sh(-(ab * gx) - pb * gy, 18));
        r.jac[4] = sat_q16(floor_sh(pa * gx + ab * gy, 18));
        r.jac[5] = sat_q16(floor_sh(-(b * gx) + a * gy, 18));
        r.invalid = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h", what, got, want);
        fail_count++;
    endtask

    function automatic int random_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
    endfunction

    task automatic send_point(t_point p);
        int gap;
        gap = random_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= p;
        do @(posedge i_clk); while (!s_axis_tready);
        jac_expected.insert(jac_expected.size(), predict_jacobian(p));
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_FOCAL_X:  fx_reg = val;
            CFG_FOCAL_Y:  fy_reg = val;
            CFG_CENTER_X: cx_reg = val;
            default:      cy_reg = val;
        endcase
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (jac_expected.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic set_intrinsics(logic [15:0] fx, logic [15:0] fy, logic [15:0] cx,
                                  logic [15:0] cy);
        drain();
        write_reg(CFG_FOCAL_X, fx);
        write_reg(CFG_FOCAL_Y, fy);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_point make_point(logic [15:0] u, logic [15:0] v, logic [15:0] d,
                                          logic [15:0] gu, logic [15:0] gv);
        t_point p;
        p.pix_u = u; p.pix_v = v; p.depth = d; p.grad_u = gu; p.grad_v = gv;
        return p;
    endfunction

    function automatic t_point random_point();
        t_point p;
        p = t_point'(80'({$urandom, $urandom, $urandom}));
        if ($urandom_range(0, 15) == 0) p.depth = 0;
        else if ($urandom_range(0, 3) == 0) p.depth = 16'($urandom_range(1, 8));
        if ($urandom_range(0, 7) == 0) p.grad_u = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
        return p;
    endfunction

    task automatic test_extremes();
        send_point(make_point(16'd5112, 16'd3832, 16'd4096, 16'd0, 16'd0));
        send_point(make_point(16'd0, 16'd0, 16'd1, 16'h8000, 16'h8000));
        send_point(make_point(16'hFFFF, 16'hFFFF, 16'd1, 16'h7FFF, 16'h7FFF));
        send_point(make_point(16'hFFFF, 16'd0, 16'hFFFF, 16'h8000, 16'h7FFF));
        send_point(make_point(16'd1234, 16'd4321, 16'd0, 16'h7FFF, 16'h8000));
        send_point(make_point(16'd6000, 16'd2000, 16'd4096, 16'h1000, 16'hF000));
        set_intrinsics(16'd16, 16'd16, 16'd0, 16'hFFFF);
        send_point(make_point(16'hFFFF, 16'd0, 16'd1, 16'h7FFF, 16'h8000));
        send_point(make_point(16'd0, 16'hFFFF, 16'd2, 16'h8000, 16'h8000));
        send_point(make_point(16'h8000, 16'h8000, 16'd0, 16'h7FFF, 16'h7FFF));
        set_intrinsics(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0);
        send_point(make_point(16'd0, 16'hFFFF, 16'd1, 16'h7FFF, 16'h7FFF));
        send_point(make_point(16'hFFFF, 16'd0, 16'hFFFF, 16'h8000, 16'h8000));
    endtask

    // With a zero focal length the ray divides by one LSB and the gradient scale is zero.
    task automatic test_zero_focal();
        set_intrinsics(16'd0, 16'd0, 16'd100, 16'd200);
        send_point(make_point(16'hFFFF, 16'd0, 16'd1, 16'h7FFF, 16'h8000));
        send_point(make_point(16'd0, 16'hFFFF, 16'd300, 16'h1234, 16'h4321));
        set_intrinsics(16'd0, 16'd8400, 16'd5112, 16'd3832);
        send_point(make_point(16'd40000, 16'd100, 16'd50, 16'h4000, 16'hC000));
    endtask

    task automatic test_random(int count, int phases);
        for (int ph = 0; ph < phases; ph++) begin
            if (ph % 2 == 0) begin
                set_intrinsics(16'($urandom_range(16, 65535)), 16'($urandom_range(16, 65535)),
                               16'($urandom), 16'($urandom));
            end else begin
                set_intrinsics(16'($urandom_range(4000, 12000)),
                               16'($urandom_range(4000, 12000)),
                               16'($urandom_range(3000, 7000)),
                               16'($urandom_range(2000, 6000)));
            end
            sink_stall_long = (ph == 1);
            for (int n = 0; n < count / phases; n++) send_point(random_point());
        end
        sink_stall_long = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b1;
        end else if ($urandom_range(0, 9) == 0) begin
            m_axis_tready <= sink_stall_long ? ($urandom_range(0, 3) == 0) : 1'b0;
        end else begin
            m_axis_tready <= sink_stall_long ? m_axis_tready : 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_jac want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (jac_expected.size() == 0) begin
                report_mismatch("unexpected beat", m_axis_tdata[31:0], 32'd0);
            end else begin
                want = jac_expected.pop_front();
                for (int k = 0; k < 6; k++) begin
                    if (m_axis_tdata[32*k +: 32] !== want.jac[k])
                        report_mismatch($sformatf("jac term %0d", k),
                                        m_axis_tdata[32*k +: 32], want.jac[k]);
                end
                if (m_axis_tuser !== want.invalid)
                    report_mismatch("depth_invalid", 32'(m_axis_tuser), 32'(want.invalid));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        fail_count      = 0;
        idle_cycles     = 0;
        sink_stall_long = 1'b0;
        fx_reg = 16'd8400; fy_reg = 16'd8400; cx_reg = 16'd5112; cy_reg = 16'd3832;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= '0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_zero_focal();
        test_random(1500, 6);
        drain();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
